>>> rtl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define SIP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sip24_pkg.sv
// Types, constants and the round function shared by the SipHash-2-4 engine modules.
`default_nettype none

package sip24_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned NBYTE_W = 4;

    localparam logic [WORD_W-1:0] SIP_C0  = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1  = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2  = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3  = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FIN = 64'h00000000000000ff;

    localparam logic [NBYTE_W-1:0] BYTES_PER_WORD = 4'd8;
    localparam logic [LEN_W-1:0]   LEN_FULL_WORD  = 8'd8;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    typedef logic [3:0][WORD_W-1:0] t_lanes;

    typedef struct packed {
        logic init;
        logic round;
        logic load;
        logic len_blk;
        logic xor_m0;
        logic fin;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic blk_full;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        t_lanes r;
        a = v[0] + v[1];
        b = rotl(v[1], 13) ^ a;
        a = rotl(a, 32);
        c = v[2] + v[3];
        d = rotl(v[3], 16) ^ c;
        a = a + d;
        d = rotl(d, 21) ^ a;
        c = c + b;
        b = rotl(b, 17) ^ c;
        c = rotl(c, 32);
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/siphash_2_4_engine_core.sv
// Top level of the keyed SipHash-2-4 engine.
//
// Usage: write key_low (index 0) and key_high (index 1) through the cfg port while idle.
// Stream the message in on s_axis as little-endian 64-bit words; tlast marks the final
// word and tuser gives its valid byte count (0..8, above 8 counts as 8; ignored on
// other words). One 64-bit hash leaves on m_axis per message.
// Throughput: one SipRound per cycle while busy, held while a finished hash still waits on
// m_axis. A non-last word is compressed with two rounds, and the next word may transfer in
// the second of them. The last word gets two rounds, then two more for a separate length
// block when it carries 8 bytes, then four finalization rounds before the hash is
// captured in the output register.
// A finished hash waits in an output register; a new message may start meanwhile, and
// if the receiver still stalls when the next hash is ready, the last round holds.
// Reset (synchronous, active low) clears the key to zero, the message state and the
// output valid.
`default_nettype none

module siphash_2_4_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [63:0] message_word
    input  wire logic [3:0]  s_axis_tuser,  // [3:0] bytes_valid
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // [63:0] hash_value
);

    sip24_pkg::t_dp_cmd cmd;
    sip24_pkg::t_dp_sts sts;

    sip24_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sip24_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (s_axis_tdata),
        .i_nbytes    (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_hash      (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/sip24_datapath.sv
// SipHash-2-4 datapath: key registers, four lanes, block and length registers, hash register.
`default_nettype none

module sip24_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [sip24_pkg::WORD_W-1:0]  i_cfg_data,
    input  wire logic [sip24_pkg::WORD_W-1:0]  i_word,
    input  wire logic [sip24_pkg::NBYTE_W-1:0] i_nbytes,
    input  wire logic                        i_last,
    input  wire sip24_pkg::t_dp_cmd          i_cmd,
    output sip24_pkg::t_dp_sts               o_sts,
    output logic [sip24_pkg::WORD_W-1:0]     o_hash
);

    logic [sip24_pkg::WORD_W-1:0] r_key_lo, r_key_hi;
    sip24_pkg::t_lanes            r_v, n_v;
    logic [sip24_pkg::WORD_W-1:0] r_m, n_m;
    logic [sip24_pkg::LEN_W-1:0]  r_len, n_len;
    logic [sip24_pkg::WORD_W-1:0] r_hash, n_hash;

    sip24_pkg::t_lanes            key_init, base, rnd;
    logic                         full;
    logic [sip24_pkg::LEN_W-1:0]  base_len, add_len, len_new;
    logic [sip24_pkg::WORD_W-1:0] masked, in_blk, blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sip24_pkg::CFG_KEY_LOW:  r_key_lo <= i_cfg_data;
                sip24_pkg::CFG_KEY_HIGH: r_key_hi <= i_cfg_data;
                default:                 r_key_lo <= r_key_lo;
            endcase
        end
    end

    always_comb begin
        key_init[0] = sip24_pkg::SIP_C0 ^ r_key_lo;
        key_init[1] = sip24_pkg::SIP_C1 ^ r_key_hi;
        key_init[2] = sip24_pkg::SIP_C2 ^ r_key_lo;
        key_init[3] = sip24_pkg::SIP_C3 ^ r_key_hi;
    end

    assign full     = (i_nbytes >= sip24_pkg::BYTES_PER_WORD);
    assign base_len = i_cmd.init ? '0 : r_len;
    assign add_len  = (!i_last || full) ? sip24_pkg::LEN_FULL_WORD
                                        : sip24_pkg::LEN_W'(i_nbytes[2:0]);
    assign len_new  = base_len + add_len;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked[i*8 +: 8] = (i < int'(i_nbytes[2:0])) ? i_word[i*8 +: 8] : 8'h00;
        end
    end

    assign in_blk = (i_last && !full) ? (masked | {len_new, 56'h0}) : i_word;
    assign blk    = i_cmd.len_blk ? {r_len, 56'h0} : in_blk;

    assign base = i_cmd.init ? key_init : r_v;
    assign rnd  = i_cmd.round ? sip24_pkg::sip_round(base) : base;

    always_comb begin
        n_v    = rnd;
        n_m    = r_m;
        n_len  = r_len;
        n_hash = r_hash;
        if (i_cmd.xor_m0) begin
            n_v[0] = rnd[0] ^ r_m;
        end
        if (i_cmd.fin) begin
            n_v[2] = rnd[2] ^ sip24_pkg::SIP_FIN;
        end
        if (i_cmd.load) begin
            n_v[3] = rnd[3] ^ blk;
            n_m    = blk;
            if (!i_cmd.len_blk) begin
                n_len = len_new;
            end
        end
        if (i_cmd.capture) begin
            n_hash = rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_m    <= n_m;
        r_len  <= n_len;
        r_hash <= n_hash;
    end

    assign o_sts.blk_full = full;
    assign o_hash         = r_hash;

endmodule

`default_nettype wire

>>> rtl/sip24_ctrl.sv
// SipHash-2-4 controller: sequences absorb, final and drain rounds and owns the handshakes.
`default_nettype none

module sip24_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_last,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire sip24_pkg::t_dp_sts i_sts,
    output sip24_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ABSORB = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       r_pend, n_pend;
    logic       r_in_msg, n_in_msg;
    logic       r_out_valid, n_out_valid;
    logic       ready, accept, out_free;

    assign ready    = (r_state == S_IDLE) ||
                      ((r_state == S_ABSORB) && (r_cnt != 2'd0) && !r_last);
    assign accept   = i_in_valid && ready && i_rst_n;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_pend      = r_pend;
        n_in_msg    = r_in_msg;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.init = !r_in_msg;
                    o_cmd.load = 1'b1;
                    n_in_msg   = 1'b1;
                    n_last     = i_in_last;
                    n_pend     = i_in_last && i_sts.blk_full;
                    n_cnt      = '0;
                    n_state    = S_ABSORB;
                end
            end
            S_ABSORB: begin
                o_cmd.round = 1'b1;
                if (r_cnt == 2'd0) begin
                    n_cnt = 2'd1;
                end else begin
                    o_cmd.xor_m0 = 1'b1;
                    n_cnt        = '0;
                    if (!r_last) begin
                        if (accept) begin
                            o_cmd.load = 1'b1;
                            n_last     = i_in_last;
                            n_pend     = i_in_last && i_sts.blk_full;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else if (r_pend) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.len_blk = 1'b1;
                        n_pend        = 1'b0;
                    end else begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (r_cnt != 2'd3) begin
                    o_cmd.round = 1'b1;
                    n_cnt       = r_cnt + 2'd1;
                end else if (out_free) begin
                    o_cmd.round   = 1'b1;
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_cnt         = '0;
                    n_in_msg      = 1'b0;
                    n_last        = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_pend      <= 1'b0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_pend      <= n_pend;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = ready && i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/sip24_checker.sv
// Port-level checker for the SipHash-2-4 engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module sip24_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `SIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `SIP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `SIP_ASSERT_NEXT(a_no_hash_after_xfer, i_clk, i_rst_n, in_xfer, !$rose(m_axis_tvalid))
    `SIP_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, in_xfer && s_axis_tlast, !s_axis_tready)
    `SIP_ASSERT_NOW(a_no_ready_in_reset, i_clk, 1'b1, !i_rst_n, !s_axis_tready)

endmodule

bind siphash_2_4_engine_core sip24_checker u_sip24_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
